FILE: rtl/open_addressing_hash_set_macros.svh
// assertion macros shared by the hash set checker
// depends on nothing; included by the checker file only
`ifndef OPEN_ADDRESSING_HASH_SET_MACROS_SVH
`define OPEN_ADDRESSING_HASH_SET_MACROS_SVH

// same-cycle implication, disabled during reset
`define OHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash set check failed");

// next-cycle implication, disabled during reset
`define OHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash set check failed");

`endif

FILE: rtl/ohs_pkg.sv
// shared constants, types and the home slot hash for the hash set
// depends on nothing; used by ohs_engine, the top level and the checker
`timescale 1ns / 1ps

package ohs_pkg;

  localparam int TABLE_BITS = 10;
  localparam int SLOT_COUNT = 1 << TABLE_BITS;
  localparam int KEY_W      = 64;
  localparam int KIND_W     = 2;
  localparam int CNT_W      = TABLE_BITS + 1;
  localparam int LIMIT_W    = 11;
  localparam int ITEM_W     = 11;
  localparam int SUM_W      = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
  localparam int OUT_W      = 16;

  localparam logic [LIMIT_W-1:0]    FILL_LIMIT_RESET = LIMIT_W'(870);
  localparam logic [TABLE_BITS-1:0] HOME_MULT        = TABLE_BITS'(73);
  localparam logic [TABLE_BITS-1:0] PROBE_STEP       = TABLE_BITS'(5009);
  localparam logic [TABLE_BITS-1:0] LAST_SLOT        = TABLE_BITS'(SLOT_COUNT - 1);
  localparam logic [KEY_W-1:0]      MARK_EMPTY       = KEY_W'(0);
  localparam logic [KEY_W-1:0]      MARK_DELETED     = KEY_W'(1);

  typedef logic [TABLE_BITS-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RESERVED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_FIN
  } state_e;

  typedef struct packed {
    logic                found;
    logic                changed;
    status_e             status;
    logic [ITEM_W-1:0]   item_count;
  } result_t;

  // low bits of key * 73 only depend on the low bits of key
  function automatic slot_idx_t home_slot(input logic [KEY_W-1:0] key);
    slot_idx_t prod;
    prod = key[TABLE_BITS-1:0] * HOME_MULT;
    return prod;
  endfunction

endpackage

FILE: rtl/ohs_ram.sv
// generic simple dual port ram, one write port and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module ohs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ohs_engine.sv
// probe sequencer: clears the slot memory, walks probe chains one slot per cycle
// depends on ohs_pkg; drives the ports of one ohs_ram instance
`timescale 1ns / 1ps

module ohs_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ohs_pkg::KIND_W-1:0]    in_kind_i,
  input  logic [ohs_pkg::KEY_W-1:0]     in_key_i,
  input  logic [ohs_pkg::LIMIT_W-1:0]   fill_limit_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ohs_pkg::result_t              res_o,
  output ohs_pkg::slot_idx_t            ram_raddr_o,
  input  logic [ohs_pkg::KEY_W-1:0]     ram_rdata_i,
  output logic                          ram_we_o,
  output ohs_pkg::slot_idx_t            ram_waddr_o,
  output logic [ohs_pkg::KEY_W-1:0]     ram_wdata_o
);

  ohs_pkg::state_e               state_q, state_d;
  ohs_pkg::slot_idx_t            pos_q, pos_d;
  ohs_pkg::slot_idx_t            n_q, n_d;
  ohs_pkg::slot_idx_t            free_q, free_d;
  logic                          has_free_q, has_free_d;
  logic [ohs_pkg::KIND_W-1:0]    kind_q, kind_d;
  logic [ohs_pkg::KEY_W-1:0]     key_q, key_d;
  ohs_pkg::cnt_t                 live_q, live_d;
  ohs_pkg::cnt_t                 del_q, del_d;
  logic                          found_q, found_d;
  logic                          changed_q, changed_d;
  ohs_pkg::status_e              status_q, status_d;

  logic                          is_empty, is_del, is_hit, is_last;
  logic                          has_now, free_is_del, at_limit;
  ohs_pkg::slot_idx_t            free_now;

  assign is_empty    = (ram_rdata_i == ohs_pkg::MARK_EMPTY);
  assign is_del      = (ram_rdata_i == ohs_pkg::MARK_DELETED);
  assign is_hit      = !is_empty && !is_del && (ram_rdata_i == key_q);
  assign is_last     = (n_q == ohs_pkg::LAST_SLOT);
  assign has_now     = has_free_q || is_empty || is_del;
  assign free_now    = has_free_q ? free_q : pos_q;
  assign free_is_del = has_free_q || is_del;
  assign at_limit    = (ohs_pkg::SUM_W'(live_q) + ohs_pkg::SUM_W'(del_q))
                       >= ohs_pkg::SUM_W'(fill_limit_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ohs_pkg::S_CLEAR;
      n_q     <= '0;
      live_q  <= '0;
      del_q   <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      live_q  <= live_d;
      del_q   <= del_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    free_q     <= free_d;
    has_free_q <= has_free_d;
    kind_q     <= kind_d;
    key_q      <= key_d;
    found_q    <= found_d;
    changed_q  <= changed_d;
    status_q   <= status_d;
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    n_d         = n_q;
    free_d      = free_q;
    has_free_d  = has_free_q;
    kind_d      = kind_q;
    key_d       = key_q;
    live_d      = live_q;
    del_d       = del_q;
    found_d     = found_q;
    changed_d   = changed_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = ohs_pkg::MARK_EMPTY;
    case (state_q)
      ohs_pkg::S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = n_q;
        n_d         = n_q + ohs_pkg::slot_idx_t'(1);
        if (is_last) begin
          state_d = ohs_pkg::S_IDLE;
        end
      end
      ohs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d     = in_kind_i;
          key_d      = in_key_i;
          pos_d      = ohs_pkg::home_slot(in_key_i);
          n_d        = '0;
          free_d     = '0;
          has_free_d = 1'b0;
          found_d    = 1'b0;
          changed_d  = 1'b0;
          status_d   = ohs_pkg::ST_OK;
          if (in_key_i == ohs_pkg::MARK_EMPTY || in_key_i == ohs_pkg::MARK_DELETED) begin
            status_d = ohs_pkg::ST_RESERVED;
            state_d  = ohs_pkg::S_FIN;
          end else begin
            state_d = ohs_pkg::S_PROBE;
          end
        end
      end
      ohs_pkg::S_PROBE: begin
        if (is_empty || is_hit || is_last) begin
          state_d = ohs_pkg::S_FIN;
          found_d = is_hit;
          case (kind_q)
            ohs_pkg::KIND_ADD: begin
              if (!is_hit) begin
                if (at_limit || !has_now) begin
                  status_d = ohs_pkg::ST_FULL;
                end else begin
                  ram_we_o    = 1'b1;
                  ram_waddr_o = free_now;
                  ram_wdata_o = key_q;
                  live_d      = live_q + ohs_pkg::cnt_t'(1);
                  changed_d   = 1'b1;
                  if (free_is_del) begin
                    del_d = del_q - ohs_pkg::cnt_t'(1);
                  end
                end
              end
            end
            ohs_pkg::KIND_REMOVE: begin
              if (is_hit) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = pos_q;
                ram_wdata_o = ohs_pkg::MARK_DELETED;
                live_d      = live_q - ohs_pkg::cnt_t'(1);
                del_d       = del_q + ohs_pkg::cnt_t'(1);
                changed_d   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else begin
          pos_d      = pos_q + ohs_pkg::PROBE_STEP;
          n_d        = n_q + ohs_pkg::slot_idx_t'(1);
          has_free_d = has_now;
          free_d     = free_now;
        end
      end
      ohs_pkg::S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ohs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ohs_pkg::S_IDLE;
      end
    endcase
  end

  // next probe address goes straight to the ram so the registered read data lines up with pos_q
  assign ram_raddr_o = pos_d;

  assign res_o.found      = found_q;
  assign res_o.changed    = changed_q;
  assign res_o.status     = status_q;
  assign res_o.item_count = ohs_pkg::ITEM_W'(live_q);

endmodule

FILE: rtl/open_addressing_hash_set.sv
// a word is probed 1 to 2^TABLE_BITS slots (none for a reserved key); the next word is
// accepted only once its result has passed from the engine into the output register
// a result waiting in the output register does not block the next accepted word
// reset: after rst_ni rises a clearing pass writes every slot empty, during which
// s_tready_o stays low; fill_limit resets to 870
// depends on ohs_pkg, ohs_ram and ohs_engine
`timescale 1ns / 1ps

module open_addressing_hash_set (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [ohs_pkg::KEY_W-1:0]      s_tdata_i,   // key
  input  logic [ohs_pkg::KIND_W-1:0]     s_tuser_i,   // kind
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [ohs_pkg::OUT_W-1:0]      m_tdata_o,   // found, changed, status, item_count
  input  logic                           cfg_we_i,
  input  logic [ohs_pkg::LIMIT_W-1:0]    cfg_wdata_i  // fill_limit
);

  logic [ohs_pkg::LIMIT_W-1:0] fill_limit_q;
  logic                        m_valid_q, m_valid_d;
  logic [ohs_pkg::OUT_W-1:0]   m_data_q, m_data_d;
  logic                        out_free;
  logic                        res_valid;
  ohs_pkg::result_t            res;
  ohs_pkg::slot_idx_t          ram_raddr, ram_waddr;
  logic [ohs_pkg::KEY_W-1:0]   ram_rdata, ram_wdata;
  logic                        ram_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_limit_q <= ohs_pkg::FILL_LIMIT_RESET;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fill_limit_q <= cfg_wdata_i;
      end
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign out_free = !m_valid_q || m_tready_i;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (out_free) begin
      m_valid_d = res_valid;
      if (res_valid) begin
        m_data_d = ohs_pkg::OUT_W'({res.item_count, res.status, res.changed, res.found});
      end
    end
  end

  ohs_ram #(
    .WIDTH (ohs_pkg::KEY_W),
    .DEPTH (ohs_pkg::SLOT_COUNT)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ohs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .in_kind_i    (s_tuser_i),
    .in_key_i     (s_tdata_i),
    .fill_limit_i (fill_limit_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_free),
    .res_o        (res),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

FILE: rtl/ohs_checker.sv
// port level checks on the result stream of the hash set, bound to the top level
// depends on ohs_pkg and open_addressing_hash_set_macros.svh
`timescale 1ns / 1ps
`include "open_addressing_hash_set_macros.svh"

module ohs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_tvalid_o,
  input logic                         m_tready_i,
  input logic [ohs_pkg::OUT_W-1:0]    m_tdata_o
);

  logic       found, changed;
  logic [1:0] status;

  assign found   = m_tdata_o[0];
  assign changed = m_tdata_o[1];
  assign status  = m_tdata_o[3:2];

  // stalled word holds
  `OHS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o))
  `OHS_ASSERT_NOW(a_status_code, clk_i, rst_ni, m_tvalid_o, status == ohs_pkg::ST_OK || status == ohs_pkg::ST_RESERVED || status == ohs_pkg::ST_FULL)
  `OHS_ASSERT_NOW(a_reserved_quiet, clk_i, rst_ni, m_tvalid_o && status == ohs_pkg::ST_RESERVED, !found && !changed)
  `OHS_ASSERT_NOW(a_change_ok, clk_i, rst_ni, m_tvalid_o && changed, status == ohs_pkg::ST_OK)

endmodule

bind open_addressing_hash_set ohs_checker u_ohs_checker (.*);
